[design/wireless_charger_ping_sequencer_macros.svh]
// Assertion macros shared by the ping sequencer modules.
`ifndef WIRELESS_CHARGER_PING_SEQUENCER_MACROS_SVH
`define WIRELESS_CHARGER_PING_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define WCPS_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define WCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define WCPS_ASSERT_ALWAYS(lbl, expr, msg)
`define WCPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/wcps_pkg.sv]
// Types, codes and constants of the ping sequencer.
`timescale 1ns / 1ps
package wcps_pkg;

   localparam int COILS = 2;

   // event kinds
   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_PACKET = 3'd1;
   localparam logic [2:0] KIND_START  = 3'd2;
   localparam logic [2:0] KIND_STOP   = 3'd3;
   localparam logic [2:0] KIND_HOLD   = 3'd4;

   // power and demodulator actions
   localparam logic [1:0] PWR_NONE = 2'd0;
   localparam logic [1:0] PWR_ON   = 2'd1;
   localparam logic [1:0] PWR_OFF  = 2'd2;
   localparam logic [1:0] DEM_NONE = 2'd0;
   localparam logic [1:0] DEM_ON   = 2'd1;
   localparam logic [1:0] DEM_OFF  = 2'd2;

   // reported events
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_STRENGTH  = 3'd1;
   localparam logic [2:0] EV_END_POWER = 3'd2;
   localparam logic [2:0] EV_ILLEGAL   = 3'd3;
   localparam logic [2:0] EV_LIMIT     = 3'd4;
   localparam logic [2:0] EV_TIMEOUT   = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_PULSE_ON  = 3'd0;
   localparam logic [2:0] CSR_CYCLE     = 3'd1;
   localparam logic [2:0] CSR_LIMIT     = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [2:0] CSR_STR_HDR   = 3'd4;
   localparam logic [2:0] CSR_END_HDR   = 3'd5;

   localparam logic [7:0] TALLY_MAX = 8'd255;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ON    = 2'd1,
      PH_OFF   = 2'd2,
      PH_FOUND = 2'd3
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        coil;
      logic [31:0] now_ms;
      logic [7:0]  pkt_header;
      logic [7:0]  pkt_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  phase_state;
      logic [1:0]  power_action;
      logic [1:0]  demod_action;
      logic [2:0]  event_code;
      logic [7:0]  strength;
      logic [7:0]  pulses_sent;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pulse_on_time;
      logic [15:0] cycle_time;
      logic [7:0]  pulse_limit;
      logic [31:0] phase_timeout;
      logic [7:0]  strength_header;
      logic [7:0]  end_power_header;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pulse_on_time:    16'd68,
      cycle_time:       16'd500,
      pulse_limit:      8'd10,
      phase_timeout:    32'd5000,
      strength_header:  8'd1,
      end_power_header: 8'd2
   };

endpackage

[design/wcps_csr.sv]
// Configuration register bank of the ping sequencer.
`timescale 1ns / 1ps
module wcps_csr
   import wcps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PULSE_ON: cfg_in.pulse_on_time    = csr_wdata[15:0];
            CSR_CYCLE:    cfg_in.cycle_time       = csr_wdata[15:0];
            CSR_LIMIT:    cfg_in.pulse_limit      = csr_wdata[7:0];
            CSR_TIMEOUT:  cfg_in.phase_timeout    = csr_wdata;
            CSR_STR_HDR:  cfg_in.strength_header  = csr_wdata[7:0];
            CSR_END_HDR:  cfg_in.end_power_header = csr_wdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/wcps_core.sv]
// Per-coil ping state and the event update logic.
`timescale 1ns / 1ps
`include "wireless_charger_ping_sequencer_macros.svh"
module wcps_core
   import wcps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type   phase_ff    [COILS];
   logic        running_ff  [COILS];
   logic [7:0]  tally_ff    [COILS];
   logic [7:0]  strength_ff [COILS];
   logic [31:0] begin_ff    [COILS];
   logic [31:0] stop_ff     [COILS];
   logic [31:0] next_ff     [COILS];

   phase_type   phase_in;
   logic        running_in;
   logic [7:0]  tally_in;
   logic [7:0]  strength_in;
   logic [31:0] begin_in;
   logic [31:0] stop_in;
   logic [31:0] next_in;

   logic        item_ok;
   logic [31:0] stop_sum;
   logic [31:0] next_sum;
   logic [31:0] to_stop;
   logic [31:0] to_next;
   logic [31:0] elapsed;
   logic        found;
   logic [1:0]  power;
   logic [1:0]  demod;
   logic [2:0]  ev;

   assign item_ok  = (req.kind <= KIND_HOLD) && (32'(req.coil) < COILS);
   assign stop_sum = req.now_ms + {16'd0, cfg.pulse_on_time};
   assign next_sum = req.now_ms + {16'd0, cfg.cycle_time};
   assign to_stop  = req.now_ms - stop_ff[req.coil];
   assign to_next  = req.now_ms - next_ff[req.coil];
   assign elapsed  = req.now_ms - begin_ff[req.coil];

   always_comb begin
      phase_in    = phase_ff[req.coil];
      running_in  = running_ff[req.coil];
      tally_in    = tally_ff[req.coil];
      strength_in = strength_ff[req.coil];
      begin_in    = begin_ff[req.coil];
      stop_in     = stop_ff[req.coil];
      next_in     = next_ff[req.coil];
      found       = 1'b0;
      power       = PWR_NONE;
      demod       = DEM_NONE;
      ev          = EV_NONE;
      case (req.kind)
         KIND_START: begin
            demod      = DEM_ON;
            power      = PWR_ON;
            phase_in   = PH_ON;
            running_in = 1'b1;
            tally_in   = 8'd1;
            begin_in   = req.now_ms;
            stop_in    = stop_sum;
            next_in    = next_sum;
         end
         KIND_STOP: begin
            if (running_ff[req.coil]) begin
               power      = PWR_OFF;
               demod      = DEM_OFF;
               phase_in   = PH_IDLE;
               running_in = 1'b0;
            end
         end
         KIND_HOLD: begin
            if (running_ff[req.coil]) begin
               phase_in   = PH_IDLE;
               running_in = 1'b0;
            end
         end
         KIND_PACKET: begin
            if (running_ff[req.coil]) begin
               if (req.pkt_header == cfg.strength_header) begin
                  strength_in = req.pkt_byte;
                  phase_in    = PH_FOUND;
                  found       = 1'b1;
                  ev          = EV_STRENGTH;
               end else if (req.pkt_header == cfg.end_power_header) begin
                  ev = EV_END_POWER;
               end else begin
                  ev = EV_ILLEGAL;
               end
            end
         end
         KIND_TICK: begin
            // a deadline counts as reached while now - deadline is below half the range
            if (running_ff[req.coil]) begin
               if (phase_ff[req.coil] == PH_ON) begin
                  if (!to_stop[31]) begin
                     power    = PWR_OFF;
                     phase_in = PH_OFF;
                  end
               end else if (phase_ff[req.coil] == PH_OFF) begin
                  if (!to_next[31]) begin
                     if (tally_ff[req.coil] != TALLY_MAX) begin
                        tally_in = tally_ff[req.coil] + 8'd1;
                     end
                     if (tally_in > cfg.pulse_limit) begin
                        ev = EV_LIMIT;
                     end else if (elapsed > cfg.phase_timeout) begin
                        ev = EV_TIMEOUT;
                     end else begin
                        power    = PWR_ON;
                        phase_in = PH_ON;
                        stop_in  = stop_sum;
                        next_in  = next_sum;
                     end
                  end
               end
            end
         end
         default: begin
            found = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp = '0;
      if (item_ok) begin
         rsp.found        = found;
         rsp.phase_state  = phase_in;
         rsp.power_action = power;
         rsp.demod_action = demod;
         rsp.event_code   = ev;
         rsp.strength     = strength_in;
         rsp.pulses_sent  = tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COILS; i++) begin
            phase_ff[i]    <= PH_IDLE;
            running_ff[i]  <= 1'b0;
            tally_ff[i]    <= 8'd0;
            strength_ff[i] <= 8'd0;
            begin_ff[i]    <= 32'd0;
            stop_ff[i]     <= 32'd0;
            next_ff[i]     <= 32'd0;
         end
      end else if (en && item_ok) begin
         phase_ff[req.coil]    <= phase_in;
         running_ff[req.coil]  <= running_in;
         tally_ff[req.coil]    <= tally_in;
         strength_ff[req.coil] <= strength_in;
         begin_ff[req.coil]    <= begin_in;
         stop_ff[req.coil]     <= stop_in;
         next_ff[req.coil]     <= next_in;
      end
   end

   `WCPS_ASSERT_ALWAYS(a_idle_when_stopped, running_ff[0] || phase_ff[0] == PH_IDLE, "stopped coil not idle")
   `WCPS_ASSERT_ALWAYS(a_tally_when_running, !running_ff[0] || tally_ff[0] != 8'd0, "running coil has no pulse")
   `WCPS_ASSERT_ALWAYS(a_found_is_strength, !en || !rsp.found || rsp.event_code == EV_STRENGTH, "found without strength event")

endmodule

[design/wireless_charger_ping_sequencer.sv]
// Top level of the per-coil digital ping sequencer.
//
// Usage:
//   Events enter on the req_ channel (req_valid, req_stall, req_data) and each
//   produces exactly one result on the rsp_ channel (rsp_valid, rsp_stall,
//   rsp_data). A transfer happens at a clock edge where valid is high and
//   stall is low.
//   Registers are written through csr_valid/csr_index/csr_wdata; csr_ready is
//   always high. Write them only while no event is in flight.
//   Each event is registered in the input register, then passes the update
//   logic into the result register, from which its result transfers.
//   Throughput: one event per cycle unless a result is stalled; the
//   per-coil state is updated in the same cycle the result register
//   loads, so the next event sees it.
//   When rsp_stall holds a waiting result, one more event is still taken
//   into the input register; req_stall rises only when both registers are
//   full and the result is stalled.
//   Reset (synchronous, active high) empties both registers, puts every coil
//   idle with zero counts and loads the register defaults.
`timescale 1ns / 1ps
`include "wireless_charger_ping_sequencer_macros.svh"
module wireless_charger_ping_sequencer
   import wcps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic    in_vld_ff;
   logic    in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff;
   logic    out_vld_in;
   rsp_type out_data_ff;
   logic    advance;
   logic    load;
   cfg_type cfg;
   rsp_type core_rsp;

   wcps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wcps_core u_core (
      .clock (clock),
      .reset (reset),
      .en    (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   // move the held event on when the result register is free or draining
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign in_vld_in  = load || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   `WCPS_ASSERT_NEXT(a_in_held, in_vld_ff && !advance, in_vld_ff && $stable(in_data_ff), "held event lost")
   `WCPS_ASSERT_NEXT(a_adv_fills, advance, out_vld_ff, "result not registered")
   `WCPS_ASSERT_ALWAYS(a_stall_full, !req_stall || (in_vld_ff && out_vld_ff && rsp_stall), "needless stall")

endmodule
